@@ hdl/epds_pkg.sv @@
`timescale 1ns / 1ps
// epds_pkg: shared types and constants of the encoder pd position servo
// depends on nothing; imported by epds_pd_law and the top level
package epds_pkg;

	localparam int GAIN_W    = 16;
	localparam int TOL_W     = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int DUTY_W    = 8;
	localparam int POS_OUT_W = 32;
	localparam int OP_W      = 2;
	localparam int FRAC_W    = 8;

	// stream payload widths, tdata padded to whole bytes
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;
	localparam int S_TUSER_W = 2;

	localparam logic signed [GAIN_W-1:0] GAIN_P_RST   = 16'sd256;
	localparam logic signed [GAIN_W-1:0] GAIN_D_RST   = 16'sd0;
	localparam logic [TOL_W-1:0]         TOL_RST      = 16'd1;
	localparam logic [DUTY_W-1:0]        DUTY_MAX     = 8'd255;
	localparam logic [DUTY_W-1:0]        DUTY_IDLE    = 8'd255;

	typedef enum logic [OP_W-1:0] {
		OP_EDGE  = 2'd0,
		OP_START = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P   = 2'd0,
		REG_GAIN_D   = 2'd1,
		REG_STOP_TOL = 2'd2
	} reg_idx_t;

	// result of one evaluation of the control law
	typedef struct packed {
		logic              dir;
		logic [DUTY_W-1:0] duty;
		logic              in_tol;
	} pd_status_t;

endpackage

@@ hdl/epds_pd_law.sv @@
`timescale 1ns / 1ps
// epds_pd_law: error, magnitude, pd speed with clamp and inverted duty
// depends on epds_pkg
module epds_pd_law #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic [COUNT_WIDTH-1:0]           target,
	input  logic [COUNT_WIDTH-1:0]           pos,
	input  logic [COUNT_WIDTH:0]             prev_mag,
	input  logic signed [epds_pkg::GAIN_W-1:0] gain_p,
	input  logic signed [epds_pkg::GAIN_W-1:0] gain_d,
	input  logic [epds_pkg::TOL_W-1:0]       tol,
	output logic [COUNT_WIDTH:0]             mag,
	output epds_pkg::pd_status_t             status
);
	import epds_pkg::*;

	localparam int EW    = COUNT_WIDTH + 1;
	localparam int DW    = COUNT_WIDTH + 2;
	localparam int PW    = DW + GAIN_W;
	localparam int QW    = PW + 1;
	localparam int CMP_W = (EW > TOL_W) ? EW : TOL_W;

	logic signed [EW-1:0] err;
	logic signed [DW-1:0] mag_s;
	logic signed [DW-1:0] prev_s;
	logic signed [DW-1:0] diff;
	logic signed [PW-1:0] prod_p;
	logic signed [PW-1:0] prod_d;
	logic signed [QW-1:0] q;
	logic [DUTY_W-1:0]    speed;

	assign err = signed'({target[COUNT_WIDTH-1], target}) - signed'({pos[COUNT_WIDTH-1], pos});
	// magnitude is at most 2^COUNT_WIDTH - 1, fits unsigned in EW bits
	assign mag    = err[EW-1] ? EW'(-err) : EW'(err);
	assign mag_s  = signed'({1'b0, mag});
	assign prev_s = signed'({1'b0, prev_mag});
	assign diff   = mag_s - prev_s;

	assign prod_p = signed'(PW'(mag_s)) * signed'(PW'(gain_p));
	assign prod_d = signed'(PW'(diff)) * signed'(PW'(gain_d));
	assign q      = signed'(QW'(prod_p)) + signed'(QW'(prod_d));

	// negative sums clamp to zero, so floor and truncation agree
	always_comb begin
		if (q[QW-1]) begin
			speed = '0;
		end else if (|q[QW-2:FRAC_W+DUTY_W]) begin
			speed = DUTY_MAX;
		end else begin
			speed = q[FRAC_W +: DUTY_W];
		end
	end

	assign status.dir    = !err[EW-1] && (err != '0);
	assign status.duty   = DUTY_MAX - speed;
	assign status.in_tol = CMP_W'(mag) < CMP_W'(tol);

endmodule

@@ hdl/encoder_pd_position_servo_core.sv @@
`timescale 1ns / 1ps
// encoder_pd_position_servo_core: top level, stream ports, state and result register
// depends on epds_pkg and epds_pd_law
// order: a transaction accepted into the input register waits there until the
//   result register is empty or being drained, then its result loads into the
//   result register and is offered on the master side
// throughput: one transaction per cycle while the master side drains results;
//   the state update for an item and its result register load happen in the same cycle
// reset: arst_n clears position, target, move and flags, loads duty 255 and
//   the gain and tolerance reset values; no clearing pass
module encoder_pd_position_servo_core #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_wen,
	input  logic [epds_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [epds_pkg::CFG_W-1:0]        cfg_wdata,
	// slave side
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [epds_pkg::S_TDATA_W-1:0]    s_tdata,  // phase_a, phase_b, target_count[31:0], pad
	input  logic [epds_pkg::S_TUSER_W-1:0]    s_tuser,  // opcode[1:0]
	// master side
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [epds_pkg::M_TDATA_W-1:0]    m_tdata,  // position[31:0], turning_cw,
	                                                    // motor_enable, direction,
	                                                    // pwm_duty[7:0], pad
	output logic                              m_tlast   // move_done
);
	import epds_pkg::*;

	localparam int TGT_LSB = 2;
	localparam int PAD_W   = M_TDATA_W - POS_OUT_W - 3 - DUTY_W;

	// input register
	logic                   valid_s1;
	logic [OP_W-1:0]        op_s1;
	logic                   pa_s1;
	logic                   pb_s1;
	logic [COUNT_WIDTH-1:0] tgt_s1;

	// configuration
	logic signed [GAIN_W-1:0] gain_p_q;
	logic signed [GAIN_W-1:0] gain_d_q;
	logic [TOL_W-1:0]         tol_q;

	// servo state
	logic [COUNT_WIDTH-1:0] pos_q;
	logic                   cw_q;
	logic [COUNT_WIDTH-1:0] target_q;
	logic                   active_q;
	logic [COUNT_WIDTH:0]   prev_mag_q;
	logic                   dir_q;
	logic [DUTY_W-1:0]      duty_q;

	// result register
	logic                   out_valid_q;
	logic [POS_OUT_W-1:0]   out_pos_q;
	logic                   out_cw_q;
	logic                   out_en_q;
	logic                   out_dir_q;
	logic [DUTY_W-1:0]      out_duty_q;
	logic                   out_done_q;

	// next state
	logic [COUNT_WIDTH-1:0] pos_d;
	logic                   cw_d;
	logic [COUNT_WIDTH-1:0] target_d;
	logic                   active_d;
	logic [COUNT_WIDTH:0]   prev_mag_d;
	logic                   dir_d;
	logic [DUTY_W-1:0]      duty_d;
	logic                   done_d;

	logic                   advance;
	logic [COUNT_WIDTH-1:0] law_target;
	logic [COUNT_WIDTH:0]   law_mag;
	pd_status_t             law_st;

	// s1 moves on whenever the result register is empty or being drained
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	// a start is judged against its new target, a tick against the held one
	assign law_target = (op_t'(op_s1) == OP_START) ? tgt_s1 : target_q;

	epds_pd_law #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_law (
		.target   (law_target),
		.pos      (pos_q),
		.prev_mag (prev_mag_q),
		.gain_p   (gain_p_q),
		.gain_d   (gain_d_q),
		.tol      (tol_q),
		.mag      (law_mag),
		.status   (law_st)
	);

	always_comb begin
		pos_d      = pos_q;
		cw_d       = cw_q;
		target_d   = target_q;
		active_d   = active_q;
		prev_mag_d = prev_mag_q;
		dir_d      = dir_q;
		duty_d     = duty_q;
		done_d     = 1'b0;
		case (op_t'(op_s1))
			OP_EDGE: begin
				// equal phase levels mean a clockwise count
				cw_d  = (pa_s1 == pb_s1);
				pos_d = (pa_s1 == pb_s1) ? pos_q + COUNT_WIDTH'(1) : pos_q - COUNT_WIDTH'(1);
			end
			OP_START: begin
				target_d = tgt_s1;
				active_d = !law_st.in_tol;
				done_d   = law_st.in_tol;
			end
			OP_TICK: begin
				if (active_q) begin
					dir_d      = law_st.dir;
					duty_d     = law_st.duty;
					prev_mag_d = law_mag;
					if (law_st.in_tol) begin
						active_d = 1'b0;
						done_d   = 1'b1;
					end
				end
			end
			default: begin
				// unused opcode leaves the state alone
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1  <= s_tuser[OP_W-1:0];
			pa_s1  <= s_tdata[0];
			pb_s1  <= s_tdata[1];
			tgt_s1 <= s_tdata[TGT_LSB +: COUNT_WIDTH];
		end
	end

	// configuration writes, index three and up ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= GAIN_P_RST;
			gain_d_q <= GAIN_D_RST;
			tol_q    <= TOL_RST;
		end else if (cfg_wen) begin
			case (reg_idx_t'(cfg_addr))
				REG_GAIN_P:   gain_p_q <= signed'(cfg_wdata);
				REG_GAIN_D:   gain_d_q <= signed'(cfg_wdata);
				REG_STOP_TOL: tol_q    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// servo state, updated once per processed transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			cw_q       <= 1'b0;
			target_q   <= '0;
			active_q   <= 1'b0;
			prev_mag_q <= '0;
			dir_q      <= 1'b0;
			duty_q     <= DUTY_IDLE;
		end else if (valid_s1 && advance) begin
			pos_q      <= pos_d;
			cw_q       <= cw_d;
			target_q   <= target_d;
			active_q   <= active_d;
			prev_mag_q <= prev_mag_d;
			dir_q      <= dir_d;
			duty_q     <= duty_d;
		end
	end

	// result register carries the state after the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_pos_q  <= POS_OUT_W'(signed'(pos_d));
			out_cw_q   <= cw_d;
			out_en_q   <= active_d;
			out_dir_q  <= dir_d;
			out_duty_q <= duty_d;
			out_done_q <= done_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {PAD_W'(0), out_duty_q, out_dir_q, out_en_q, out_cw_q, out_pos_q};
	assign m_tlast  = out_done_q;

endmodule
